// ===== hdl/gmdf_pkg.sv =====
// Shared types and constants for the greedy minimum-distance filter.
// Used by gmdf_cell and greedy_min_distance_filter; no dependencies.
`timescale 1ns / 1ps

package gmdf_pkg;

   // Field widths fixed by the interface
   localparam int COORD_W = 24;                 // signed coordinate, 8 fraction bits
   localparam int DIST_W  = 23;                 // unsigned threshold, 8 fraction bits
   localparam int INDEX_W = 20;                 // output index
   localparam int ABS_W   = COORD_W + 1;        // |a - b| needs one more bit
   localparam int SQ_W    = 2 * COORD_W + 1;    // (2^24)^2 = 2^48
   localparam int SUM_W   = SQ_W + 1;           // sum of three squares
   localparam int MD2_W   = 2 * DIST_W;         // squared threshold

   typedef logic signed [COORD_W-1:0] coord_type;

   // One input item
   typedef struct packed {
      logic               first_of_set;
      coord_type          point_x;
      coord_type          point_y;
      coord_type          point_z;
      logic [INDEX_W-1:0] out_index;
   } req_type;

   // One result item
   typedef struct packed {
      logic [INDEX_W-1:0] result_index;
      logic               keep;
      logic               store_overflow;
   } rsp_type;

   // Candidate point travelling down the chain of cells
   typedef struct packed {
      logic               active;   // slot holds a candidate
      logic               first;    // candidate opens a new set
      logic               placed;   // already written into a cell
      logic               hit;      // a kept point lies too close
      coord_type          point_x;
      coord_type          point_y;
      coord_type          point_z;
      logic [INDEX_W-1:0] index;
   } token_type;

endpackage

// ===== hdl/gmdf_cell.sv =====
// One cell of the kept-point chain: holds one kept point and tests the
// passing candidate against it over two register stages. Uses gmdf_pkg.
`timescale 1ns / 1ps

module gmdf_cell
   import gmdf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [MD2_W-1:0] md2,
   input  token_type        tok_in,
   output token_type        tok_out
);

   // Stored kept point and its occupancy flag
   coord_type  entry_x_ff, entry_y_ff, entry_z_ff;
   logic       valid_ff, valid_in;

   // Stage A: squared per-axis distances
   token_type        a_tok_ff;
   logic             a_valid_ff;
   logic [SQ_W-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0]  sq_x_in, sq_y_in, sq_z_in;

   // Stage B: decision
   token_type        b_tok_ff, b_tok_in;
   logic             place;
   logic             clear;

   logic [ABS_W-1:0]   dx, dy, dz;
   logic [ABS_W-1:0]   ax, ay, az;
   logic [2*ABS_W-1:0] px, py, pz;
   logic [SUM_W-1:0]   dist2;
   logic               near;

   // Absolute differences and squares against the stored point
   always_comb begin
      dx = {tok_in.point_x[COORD_W-1], tok_in.point_x} - {entry_x_ff[COORD_W-1], entry_x_ff};
      dy = {tok_in.point_y[COORD_W-1], tok_in.point_y} - {entry_y_ff[COORD_W-1], entry_y_ff};
      dz = {tok_in.point_z[COORD_W-1], tok_in.point_z} - {entry_z_ff[COORD_W-1], entry_z_ff};
      ax = dx[ABS_W-1] ? (~dx + 1'b1) : dx;
      ay = dy[ABS_W-1] ? (~dy + 1'b1) : dy;
      az = dz[ABS_W-1] ? (~dz + 1'b1) : dz;
      px = ax * ax;
      py = ay * ay;
      pz = az * az;
      sq_x_in = px[SQ_W-1:0];
      sq_y_in = py[SQ_W-1:0];
      sq_z_in = pz[SQ_W-1:0];
   end

   // Sum of squares against the squared threshold, strictly less
   always_comb begin
      dist2 = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
      near  = dist2 < SUM_W'(md2);
   end

   // Decide: compare, claim the first empty cell, or clear for a new set
   always_comb begin
      b_tok_in = a_tok_ff;
      place    = 1'b0;
      clear    = 1'b0;
      if (a_tok_ff.active) begin
         if (a_tok_ff.first) begin
            // new set: take the head cell, empty every cell after it
            if (!a_tok_ff.placed) begin
               place = 1'b1;
            end else begin
               clear = 1'b1;
            end
         end else if (a_valid_ff) begin
            if (near && !a_tok_ff.placed) begin
               b_tok_in.hit = 1'b1;
            end
         end else if (!a_tok_ff.hit && !a_tok_ff.placed) begin
            place = 1'b1;
         end
      end
      if (place) begin
         b_tok_in.placed = 1'b1;
      end
      valid_in = place ? 1'b1 : (clear ? 1'b0 : valid_ff);
   end

   // Stage registers and stored point; only the slot flags are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         a_tok_ff.active <= 1'b0;
         b_tok_ff.active <= 1'b0;
      end else if (advance) begin
         valid_ff   <= valid_in;
         a_tok_ff   <= tok_in;
         a_valid_ff <= valid_ff;
         sq_x_ff    <= sq_x_in;
         sq_y_ff    <= sq_y_in;
         sq_z_ff    <= sq_z_in;
         b_tok_ff   <= b_tok_in;
         if (place) begin
            entry_x_ff <= a_tok_ff.point_x;
            entry_y_ff <= a_tok_ff.point_y;
            entry_z_ff <= a_tok_ff.point_z;
         end
      end
   end

   assign tok_out = b_tok_ff;

endmodule

// ===== hdl/greedy_min_distance_filter.sv =====
// A candidate passes both register stages of every cell, then the output register.
// Input is refused while entered_ff is set; each cell spends two stages (square,
// then sum and compare) on a candidate, and the next one trails by at least two.
// The whole chain holds while a result waits and rsp_ready is low.
// Synchronous active-high reset empties the store and sets min_distance to 0.
// Top level of the greedy minimum-distance filter; uses gmdf_pkg, gmdf_cell.
`timescale 1ns / 1ps

module greedy_min_distance_filter
   import gmdf_pkg::*;
#(
   parameter int KEPT_DEPTH = 1024,
   parameter int INDEX_BITS = 20
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DIST_W-1:0] csr_data
);

   localparam int IDX_KEEP = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
   localparam logic [INDEX_W-1:0] IDX_MASK = INDEX_W'((64'd1 << IDX_KEEP) - 64'd1);

   logic              advance;
   logic              accept;
   logic              entered_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [MD2_W-1:0]  md2_ff, md2_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;
   token_type         head_tok;
   token_type         chain [0:KEPT_DEPTH];

   // Chain moves unless a result is stuck at the output
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !entered_ff;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Candidate entering the head cell
   always_comb begin
      head_tok.active  = accept;
      head_tok.first   = req_data.first_of_set;
      head_tok.placed  = 1'b0;
      head_tok.hit     = 1'b0;
      head_tok.point_x = req_data.point_x;
      head_tok.point_y = req_data.point_y;
      head_tok.point_z = req_data.point_z;
      head_tok.index   = req_data.out_index & IDX_MASK;
   end
   assign chain[0] = head_tok;

   // Row of kept-point cells
   for (genvar i = 0; i < KEPT_DEPTH; i++) begin : g_cell
      gmdf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .md2     (md2_ff),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   // Threshold register and its square
   assign md2_in = dist_ff * dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
         md2_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            dist_ff <= csr_data;
         end
         md2_ff <= md2_in;
      end
   end

   // Result from the tail of the chain; neither hit nor placed means the store was full
   always_comb begin
      rsp_data_in.result_index   = chain[KEPT_DEPTH].index;
      rsp_data_in.keep           = !chain[KEPT_DEPTH].hit;
      rsp_data_in.store_overflow = !chain[KEPT_DEPTH].hit && !chain[KEPT_DEPTH].placed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entered_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         entered_ff   <= accept;
         rsp_valid_ff <= chain[KEPT_DEPTH].active;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Overflow is only ever reported on a kept point
   a_overflow_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.keep || !rsp_data.store_overflow))
      else $error("overflow flagged on a dropped point");

   // Candidates stay at least two stages apart in the chain
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken on consecutive cycles");

   // A held result freezes the chain, so no new input is taken
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while the chain is held");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for greedy_min_distance_filter: directed and random point sets.
// A behavioral predictor checks every result. Depends on gmdf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_top;
   import gmdf_pkg::*;

   localparam int     KEPT_DEPTH     = 1024;
   localparam int     INDEX_BITS     = 20;
   localparam int     RESULT_LATENCY = 2 * KEPT_DEPTH + 1;
   localparam int     CYCLE_LIMIT    = 400000;
   localparam longint COORD_MAX      = 64'sd8388607;
   localparam longint COORD_MIN      = -64'sd8388608;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [DIST_W-1:0] csr_data  = '0;

   // Predictor state: kept points of the current set and the threshold
   coord_type         store_x [KEPT_DEPTH];
   coord_type         store_y [KEPT_DEPTH];
   coord_type         store_z [KEPT_DEPTH];
   int                store_fill = 0;
   logic [DIST_W-1:0] limit_dist = '0;

   rsp_type pending_results [$];
   int      failures    = 0;
   int      cycle_count = 0;
   int      rsp_wait    = 0;
   bit      idle_on     = 1'b1;

   greedy_min_distance_filter #(
      .KEPT_DEPTH(KEPT_DEPTH),
      .INDEX_BITS(INDEX_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("** greedy_min_distance_filter: FAILED **");
         $finish;
      end
   end

   // Result side: random stall after each transfer while idle_on is set
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         w = idle_on ? $urandom_range(0, 4) : 0;
         rsp_wait  <= w;
         rsp_ready <= (w == 0);
      end else if (rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_wait  <= 0;
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, index %0d keep %0b overflow %0b", $time,
                     rsp_data.result_index, rsp_data.keep, rsp_data.store_overflow);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_index !== want.result_index) begin
               $display("%0t: result_index mismatch: expected %0d, actual %0d", $time,
                        want.result_index, rsp_data.result_index);
               failures++;
            end
            if (rsp_data.keep !== want.keep) begin
               $display("%0t: keep mismatch (index %0d): expected %0b, actual %0b", $time,
                        want.result_index, want.keep, rsp_data.keep);
               failures++;
            end
            if (rsp_data.store_overflow !== want.store_overflow) begin
               $display("%0t: store_overflow mismatch (index %0d): expected %0b, actual %0b",
                        $time, want.result_index, want.store_overflow,
                        rsp_data.store_overflow);
               failures++;
            end
         end
      end
   end

   // Greedy suppression: keep the point unless a stored point is strictly closer
   function automatic rsp_type predict_filter(input req_type item);
      longint  dx, dy, dz, d2, limit2;
      bit      keep;
      int      k;
      rsp_type r;
      if (item.first_of_set) store_fill = 0;
      limit2 = longint'(limit_dist) * longint'(limit_dist);
      keep   = 1'b1;
      for (k = 0; k < store_fill; k++) begin
         dx = longint'(item.point_x) - longint'(store_x[k]);
         dy = longint'(item.point_y) - longint'(store_y[k]);
         dz = longint'(item.point_z) - longint'(store_z[k]);
         d2 = dx * dx + dy * dy + dz * dz;
         if (d2 < limit2) begin
            keep = 1'b0;
            break;
         end
      end
      r.result_index   = item.out_index;
      r.keep           = keep;
      r.store_overflow = 1'b0;
      if (keep) begin
         if (store_fill < KEPT_DEPTH) begin
            store_x[store_fill] = item.point_x;
            store_y[store_fill] = item.point_y;
            store_z[store_fill] = item.point_z;
            store_fill++;
         end else begin
            r.store_overflow = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic coord_type clamp_coord(input longint v);
      coord_type c;
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      c = v[COORD_W-1:0];
      return c;
   endfunction

   function automatic longint rand_coord();
      coord_type c;
      c = COORD_W'($urandom);
      return longint'(c);
   endfunction

   function automatic req_type make_point(input bit first, input longint x, input longint y,
                                          input longint z, input int unsigned idx);
      req_type p;
      p.first_of_set = first;
      p.point_x      = clamp_coord(x);
      p.point_y      = clamp_coord(y);
      p.point_z      = clamp_coord(z);
      p.out_index    = idx[INDEX_W-1:0];
      return p;
   endfunction

   // One input transfer; valid stays high when the next point follows at once
   task automatic send_point(input req_type item);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_filter(item));
   endtask

   // Hold off the sender until every predicted result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic set_min_distance(input logic [DIST_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      limit_dist = value;
   endtask

   // Threshold left at its reset value of zero: coincident and extreme points all kept
   task automatic test_reset_threshold();
      send_point(make_point(1'b1, COORD_MIN, COORD_MIN, COORD_MIN, 0));
      send_point(make_point(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, 1));
      send_point(make_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFFF));
      send_point(make_point(1'b0, 0, 0, 0, 32'hFFFFF));
   endtask

   // Points exactly at the threshold are kept, closer ones dropped
   task automatic test_exact_limit();
      drain_results();
      set_min_distance(23'd1024);
      send_point(make_point(1'b1, 0, 0, 0, 10));
      send_point(make_point(1'b0, 1024, 0, 0, 11));
      send_point(make_point(1'b0, 512, 0, 0, 12));
      send_point(make_point(1'b0, 0, 0, 1023, 13));
      send_point(make_point(1'b0, -1024, 0, 0, 13));
      send_point(make_point(1'b0, 0, 0, 0, 14));
      send_point(make_point(1'b0, 600, 600, 600, 15));
      // new set: the store starts empty again
      send_point(make_point(1'b1, 0, 0, 0, 16));
   endtask

   // Largest threshold against opposite corners of the coordinate range
   task automatic test_max_threshold();
      drain_results();
      set_min_distance(DIST_MAX);
      send_point(make_point(1'b1, COORD_MIN, COORD_MIN, COORD_MIN, 20));
      send_point(make_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 21));
      send_point(make_point(1'b0, 0, 0, 0, 22));
      send_point(make_point(1'b0, 4194304, 0, 0, 23));
      send_point(make_point(1'b0, COORD_MAX, COORD_MIN, 0, 24));
   endtask

   // Fill the store, then keep passing points with overflow set
   task automatic test_store_overflow();
      int k;
      drain_results();
      set_min_distance('0);
      idle_on = 1'b0;
      for (k = 0; k < KEPT_DEPTH + 6; k++)
         send_point(make_point(k == 0, k * 16, 0, 0, k));
      drain_results();
      set_min_distance(23'd256);
      idle_on = 1'b1;
      send_point(make_point(1'b0, 32, 0, 0, 100));
      send_point(make_point(1'b0, 0, 1000000, 0, 101));
      send_point(make_point(1'b0, 16 * 1023 + 8, 0, 0, 102));
      send_point(make_point(1'b0, -5000, -5000, 5000, 103));
   endtask

   // Sets of clustered points around a random center, with noise mixed in
   task automatic run_random_phase(input logic [DIST_W-1:0] thr, input int count);
      int     sent, set_len, j, pick, axis;
      longint cx, cy, cz, spread, off, px, py, pz;
      drain_results();
      set_min_distance(thr);
      idle_on = ($urandom_range(0, 3) != 0);
      spread  = 2 * longint'(thr) + 8;
      sent    = 0;
      while (sent < count) begin
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(1, 16);
         cx = rand_coord();
         cy = rand_coord();
         cz = rand_coord();
         for (j = 0; j < set_len; j++) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               send_point(make_point($urandom_range(0, 1) != 0, rand_coord(), rand_coord(),
                                     rand_coord(), $urandom));
            end else if (j == 0) begin
               send_point(make_point(1'b1, cx, cy, cz, $urandom));
            end else if (pick < 4) begin
               // exactly on the threshold from the set's center
               off  = $urandom_range(0, 1) ? longint'(thr) : -longint'(thr);
               axis = $urandom_range(0, 2);
               px = cx; py = cy; pz = cz;
               case (axis)
                  0: px = cx + off;
                  1: py = cy + off;
                  default: pz = cz + off;
               endcase
               send_point(make_point(1'b0, px, py, pz, $urandom));
            end else begin
               px = cx + longint'($urandom_range(0, 2 * spread)) - spread;
               py = cy + longint'($urandom_range(0, 2 * spread)) - spread;
               pz = cz + longint'($urandom_range(0, 2 * spread)) - spread;
               send_point(make_point(1'b0, px, py, pz, $urandom));
            end
            sent++;
            if (sent % 200 == 0) drain_results();
         end
      end
   endtask

   task automatic test_random_sets();
      run_random_phase(23'($urandom_range(1, 4096)), 50);
      run_random_phase('0, 50);
      run_random_phase(DIST_MAX, 50);
      run_random_phase(23'($urandom_range(4097, 8388606)), 50);
      run_random_phase(23'($urandom_range(1, 300)), 50);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_threshold();
      test_exact_limit();
      test_max_threshold();
      test_store_overflow();
      test_random_sets();
      drain_results();
      repeat (RESULT_LATENCY) @(posedge clock);
      if (failures == 0) begin
         $display("** greedy_min_distance_filter: PASSED **");
      end else begin
         $display("** greedy_min_distance_filter: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/gmdf_pkg.sv
hdl/gmdf_cell.sv
hdl/greedy_min_distance_filter.sv
verif/tb_top.sv
